>>> rtl/core/pgh_pkg.sv
package pgh_pkg;

  localparam int CoordW = 24;
  localparam int RadW   = 16;
  localparam int ThrW   = 16;
  localparam int InW    = 176;
  localparam int UserW  = 2;
  localparam int OutW   = 16;
  localparam int LevelW = 13;
  localparam int AbsW   = 25;
  localparam int SumW   = 50;
  localparam int RootW  = 25;
  localparam int RemW   = 28;
  localparam int GapW   = 27;
  localparam int DenW   = 17;
  localparam int QW     = 12;
  localparam int CntW   = 5;
  localparam int CfgIdxW = 3;

  localparam logic [CntW-1:0] SqrLast  = CntW'(4);
  localparam logic [CntW-1:0] RootLast = CntW'(RootW - 1);
  localparam logic [CntW-1:0] DivLast  = CntW'(QW - 1);
  localparam logic [CntW-1:0] AxisLast = CntW'(2);

  localparam logic [LevelW-1:0] LevelOne = LevelW'(4096);

  localparam logic [ThrW-1:0] PinchOnReset   = 16'd655;
  localparam logic [ThrW-1:0] PinchHoldReset = 16'd983;
  localparam logic [ThrW-1:0] PinchZeroReset = 16'd5243;
  localparam logic [ThrW-1:0] GripOnReset    = 16'd3277;
  localparam logic [ThrW-1:0] GripHoldReset  = 16'd3932;
  localparam logic [ThrW-1:0] GripZeroReset  = 16'd7209;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PINCH_ON   = 3'd0,
    REG_PINCH_HOLD = 3'd1,
    REG_PINCH_ZERO = 3'd2,
    REG_GRIP_ON    = 3'd3,
    REG_GRIP_HOLD  = 3'd4,
    REG_GRIP_ZERO  = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQR,
    ST_ROOT,
    ST_GAP,
    ST_LVL,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic            load;
    logic            sqr;
    logic            root;
    logic            gap;
    logic            lvl;
    logic            div;
    logic            fin;
    logic [CntW-1:0] cnt;
  } ctrl_t;

endpackage

>>> rtl/core/pgh_seq.sv
module pgh_seq (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          skip_div,
  input  logic          out_free,
  output logic          idle,
  output pgh_pkg::ctrl_t ctrl
);
  import pgh_pkg::*;

  state_t          state, state_next;
  logic [CntW-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt + 1'b1;
    case (state)
      ST_IDLE: begin
        cnt_next = '0;
        if (start) state_next = ST_SQR;
      end
      ST_SQR: begin
        if (cnt == SqrLast) begin
          state_next = ST_ROOT;
          cnt_next   = '0;
        end
      end
      ST_ROOT: begin
        if (cnt == RootLast) begin
          state_next = ST_GAP;
          cnt_next   = '0;
        end
      end
      ST_GAP: begin
        state_next = ST_LVL;
        cnt_next   = '0;
      end
      ST_LVL: begin
        state_next = skip_div ? ST_DONE : ST_DIV;
        cnt_next   = '0;
      end
      ST_DIV: begin
        if (cnt == DivLast) begin
          state_next = ST_DONE;
          cnt_next   = '0;
        end
      end
      ST_DONE: begin
        cnt_next = '0;
        if (out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
        cnt_next   = '0;
      end
    endcase
  end

  always_comb begin
    idle      = 1'b0;
    ctrl      = '0;
    ctrl.cnt  = cnt;
    case (state)
      ST_IDLE: begin
        idle      = 1'b1;
        ctrl.load = start;
      end
      ST_SQR:  ctrl.sqr  = 1'b1;
      ST_ROOT: ctrl.root = 1'b1;
      ST_GAP:  ctrl.gap  = 1'b1;
      ST_LVL:  ctrl.lvl  = 1'b1;
      ST_DIV:  ctrl.div  = 1'b1;
      ST_DONE: ctrl.fin  = out_free;
      default: idle      = 1'b0;
    endcase
  end

endmodule

>>> rtl/core/pgh_arith.sv
module pgh_arith (
  input  logic                      clk,
  input  pgh_pkg::ctrl_t            ctrl,
  input  logic [pgh_pkg::InW-1:0]   item,
  input  logic [pgh_pkg::ThrW-1:0]  thr_on,
  input  logic [pgh_pkg::ThrW-1:0]  thr_hold,
  input  logic [pgh_pkg::ThrW-1:0]  thr_zero,
  input  logic                      prev,
  output logic                      skip_div,
  output logic                      now,
  output logic [pgh_pkg::LevelW-1:0] level
);
  import pgh_pkg::*;

  logic [InW-1:0]   item_r;
  logic [AbsW-1:0]  ad;
  logic [SumW-1:0]  prod;
  logic [SumW-1:0]  acc;
  logic [SumW-1:0]  rad;
  logic [RootW-1:0] root;
  logic [RemW-1:0]  rem;
  logic signed [GapW-1:0] d;
  logic [ThrW-1:0]  t;
  logic [LevelW-1:0] q;

  logic signed [CoordW-1:0] pa, pb;
  logic signed [AbsW-1:0]   diff;
  logic [AbsW-1:0]          diff_abs;
  logic [SumW-1:0]          src;
  logic [RootW-1:0]         cur_root;
  logic [RemW-1:0]          cur_rem;
  logic [RemW-1:0]          rem_sh;
  logic [RemW-1:0]          opa, opb;
  logic [RemW:0]            sub;
  logic                     ge;
  logic [ThrW-1:0]          t_sel;
  logic signed [GapW-1:0]   d_calc;
  logic signed [DenW-1:0]   denom;
  logic signed [RemW-1:0]   num;
  logic                     num_ge;

  always_comb begin
    case (ctrl.cnt[1:0])
      2'd0: begin
        pa = item_r[23:0];
        pb = item_r[95:72];
      end
      2'd1: begin
        pa = item_r[47:24];
        pb = item_r[119:96];
      end
      default: begin
        pa = item_r[71:48];
        pb = item_r[143:120];
      end
    endcase
    diff     = AbsW'(pa) - AbsW'(pb);
    diff_abs = diff[AbsW-1] ? AbsW'(-diff) : AbsW'(diff);
  end

  // shared compare-subtract unit: root digits and quotient bits
  always_comb begin
    src      = (ctrl.cnt == '0) ? acc : rad;
    cur_root = (ctrl.cnt == '0) ? '0 : root;
    cur_rem  = (ctrl.cnt == '0) ? '0 : rem;
    rem_sh   = {cur_rem[RemW-3:0], src[SumW-1 -: 2]};
    if (ctrl.div) begin
      opa = {11'b0, rem[15:0], 1'b0};
      opb = {12'b0, thr_zero - t};
    end else begin
      opa = rem_sh;
      opb = {1'b0, cur_root, 2'b01};
    end
    sub = {1'b0, opa} - {1'b0, opb};
    ge  = !sub[RemW];
  end

  always_comb begin
    t_sel  = prev ? thr_hold : thr_on;
    d_calc = $signed({2'b0, root}) - $signed({11'b0, item_r[159:144]})
           - $signed({11'b0, item_r[175:160]});
    denom  = $signed({1'b0, thr_zero}) - $signed({1'b0, t});
    num    = $signed({12'b0, thr_zero}) - $signed({d[GapW-1], d});
    num_ge = num >= $signed({{(RemW-DenW){denom[DenW-1]}}, denom});
    skip_div = (denom <= 0) || (num <= 0) || num_ge;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      item_r <= item;
      acc    <= '0;
    end
    if (ctrl.sqr) begin
      if (ctrl.cnt <= AxisLast) ad <= diff_abs;
      if (ctrl.cnt >= CntW'(1) && ctrl.cnt <= CntW'(3)) prod <= ad * ad;
      if (ctrl.cnt >= CntW'(2)) acc <= acc + prod;
    end
    if (ctrl.root) begin
      rad <= {src[SumW-3:0], 2'b00};
      if (ge) begin
        rem  <= sub[RemW-1:0];
        root <= {cur_root[RootW-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {cur_root[RootW-2:0], 1'b0};
      end
    end
    if (ctrl.gap) begin
      d   <= d_calc;
      t   <= t_sel;
      now <= d_calc <= $signed({11'b0, t_sel});
    end
    if (ctrl.lvl) begin
      rem <= {12'b0, num[15:0]};
      if (denom <= 0) q <= now ? LevelOne : '0;
      else if (num <= 0) q <= '0;
      else if (num_ge) q <= LevelOne;
      else q <= '0;
    end
    if (ctrl.div) begin
      q <= {q[LevelW-2:0], ge};
      if (ge) rem <= {12'b0, sub[15:0]};
      else rem <= opa;
    end
  end

  assign level = q;

endmodule

>>> rtl/core/pinch_grip_hysteresis_detector_unit.sv
// Pinch and grip detector with hysteresis. Each input transaction carries two
// 3D points, their radii and a gesture/hand selector; the block returns one
// result transaction with the active, just-on and just-off flags and a 0..4096
// activation level. One item is worked at a time: the squares are summed, then
// a 25-step square root runs through the one shared compare-subtract unit; the
// result follows directly when the level is saturated or zero, or after a
// 12-step division through the same unit when a level between is needed. The
// input is not ready while an item is in progress; a finished result waits in
// the output register and the next item is taken meanwhile. Registers reset to
// the default thresholds and every hand and gesture starts inactive.
module pinch_grip_hysteresis_detector_unit #(
  parameter int HANDS = 2
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, a_radius, b_radius
  input  logic [pgh_pkg::InW-1:0]     s_axis_tdata,
  // func, hand
  input  logic [pgh_pkg::UserW-1:0]   s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // active, just_on, just_off, activation
  output logic [pgh_pkg::OutW-1:0]    m_axis_tdata,
  // out_hand, out_func
  output logic [pgh_pkg::UserW-1:0]   m_axis_tuser,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [pgh_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [pgh_pkg::ThrW-1:0]    cfg_data
);
  import pgh_pkg::*;

  localparam int Slots = HANDS * 2;
  localparam int SlotW = $clog2(Slots);

  logic [ThrW-1:0] pinch_on, pinch_hold, pinch_zero;
  logic [ThrW-1:0] grip_on, grip_hold, grip_zero;
  logic [Slots-1:0] was_active;
  logic             func, hand;
  logic             idle, start, skip_div, out_free, now;
  logic [LevelW-1:0] level;
  logic [SlotW-1:0] slot;
  logic             in_range, prev;
  logic [ThrW-1:0]  thr_on, thr_hold, thr_zero;
  ctrl_t            ctrl;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = idle;
  assign start         = s_axis_tvalid && idle;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pinch_on   <= PinchOnReset;
      pinch_hold <= PinchHoldReset;
      pinch_zero <= PinchZeroReset;
      grip_on    <= GripOnReset;
      grip_hold  <= GripHoldReset;
      grip_zero  <= GripZeroReset;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PINCH_ON:   pinch_on   <= cfg_data;
        REG_PINCH_HOLD: pinch_hold <= cfg_data;
        REG_PINCH_ZERO: pinch_zero <= cfg_data;
        REG_GRIP_ON:    grip_on    <= cfg_data;
        REG_GRIP_HOLD:  grip_hold  <= cfg_data;
        REG_GRIP_ZERO:  grip_zero  <= cfg_data;
        default:        pinch_on   <= pinch_on;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      func <= s_axis_tuser[0];
      hand <= s_axis_tuser[1];
    end
  end

  assign slot     = SlotW'({hand, func});
  assign in_range = 32'(hand) < HANDS;
  assign prev     = in_range && was_active[slot];
  assign thr_on   = func ? grip_on : pinch_on;
  assign thr_hold = func ? grip_hold : pinch_hold;
  assign thr_zero = func ? grip_zero : pinch_zero;

  pgh_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .skip_div (skip_div),
    .out_free (out_free),
    .idle     (idle),
    .ctrl     (ctrl)
  );

  pgh_arith u_arith (
    .clk      (clk),
    .ctrl     (ctrl),
    .item     (s_axis_tdata),
    .thr_on   (thr_on),
    .thr_hold (thr_hold),
    .thr_zero (thr_zero),
    .prev     (prev),
    .skip_div (skip_div),
    .now      (now),
    .level    (level)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      was_active <= '0;
    end else if (ctrl.fin && in_range) begin
      was_active[slot] <= now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (ctrl.fin) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.fin) begin
      m_axis_tuser <= {func, hand};
      m_axis_tdata <= {level, !now && prev, now && !prev, now};
    end
  end

endmodule

>>> rtl/core/pgh_checker.sv
module pgh_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [15:0]  m_axis_tdata
);

  // drop ready for the next item once a transaction is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready after accept");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[15:3] <= 13'd4096)
    else $error("activation out of range");

  a_flags: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[1] && !m_axis_tdata[0])
                   && !(m_axis_tdata[2] && m_axis_tdata[0]))
    else $error("edge flag disagrees with active");

  a_level_active: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[15:3] != 13'd0)
    else $error("gesture turned on with zero level");

endmodule

bind pinch_grip_hysteresis_detector_unit pgh_checker u_pgh_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
